/* design/per_mark_traffic_accounting_table_unit_macros.svh */
// Assertion macros for the per-mark traffic accounting table.
// Used by the top level; depends on nothing else.
`ifndef PER_MARK_TRAFFIC_ACCOUNTING_TABLE_UNIT_MACROS_SVH
`define PER_MARK_TRAFFIC_ACCOUNTING_TABLE_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PMT_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication.
`define PMT_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* design/pmtat_pkg.sv */
// Package for the per-mark traffic accounting table: codes, widths, payload types.
// No dependencies.
`default_nettype none
package pmtat_pkg;
	localparam int DefEntries = 32;
	localparam logic [31:0] DefBase = 32'd10000;
	localparam logic [31:0] DefOffset = 32'd10000;

	localparam logic [2:0] ACT_LIVE = 3'd0;
	localparam logic [2:0] ACT_GONE = 3'd1;
	localparam logic [2:0] ACT_DENY = 3'd2;
	localparam logic [2:0] ACT_PASS = 3'd3;
	localparam logic [2:0] ACT_EXPORT = 3'd4;

	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_UNKNOWN = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;
	localparam logic [2:0] ST_EXPORT = 3'd5;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_OFFSET = 1'b1;

	// one counter row of the table
	typedef struct packed {
		logic [63:0] live_in;
		logic [63:0] live_out;
		logic [63:0] gone_in;
		logic [63:0] gone_out;
		logic [63:0] den_in;
		logic [63:0] den_out;
	} cnt_row_t;

	// result beat
	typedef struct packed {
		logic [2:0] status;
		logic entry_valid;
		logic [31:0] export_mark;
		logic [63:0] total_in;
		logic [63:0] total_out;
		logic [63:0] denied_in_total;
		logic [63:0] denied_out_total;
		logic last;
	} res_t;
endpackage
`default_nettype wire

/* design/pmtat_store.sv */
// Synchronous table memory: one key and counter row per entry, registered read.
// Depends on pmtat_pkg.
`default_nettype none
module pmtat_store
	import pmtat_pkg::*;
#(
	parameter int Entries = DefEntries,
	localparam int AW = (Entries > 1) ? $clog2(Entries) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [31:0] wkey,
	input wire cnt_row_t wrow,
	input wire logic [AW-1:0] raddr,
	output logic [31:0] rkey,
	output cnt_row_t rrow
);
	logic [31:0] key_mem [Entries];
	cnt_row_t row_mem [Entries];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			row_mem[waddr] <= wrow;
		end
		rkey <= key_mem[raddr];
		rrow <= row_mem[raddr];
	end
endmodule
`default_nettype wire

/* design/pmtat_merge.sv */
// Export merge buffer: accumulates merged entries and reads them back.
// Depends on pmtat_pkg.
`default_nettype none
module pmtat_merge
	import pmtat_pkg::*;
#(
	parameter int Entries = DefEntries,
	localparam int AW = (Entries > 1) ? $clog2(Entries) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [31:0] wkey,
	input wire logic [255:0] wsum,
	input wire logic [AW-1:0] raddr,
	output logic [31:0] rkey,
	output logic [255:0] rsum
);
	logic [31:0] key_mem [Entries];
	logic [255:0] sum_mem [Entries];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			sum_mem[waddr] <= wsum;
		end
		rkey <= key_mem[raddr];
		rsum <= sum_mem[raddr];
	end
endmodule
`default_nettype wire

/* design/per_mark_traffic_accounting_table_unit.sv */
// Top level of the per-mark traffic accounting table: sequencer and ports.
// Depends on pmtat_pkg, pmtat_store, pmtat_merge and the macros header.
//
// Usage:
//  - s_axis carries one command beat (action, mark, byte counts, denied
//    direction and size); m_axis returns result beats; cfg_we/cfg_idx/cfg_data
//    write inbound_mark_base (index 0) and inbound_mark_offset (index 1).
//  - Samples walk the key table from the memory read port, a read state and
//    a compare state per entry, then the row write-back where there is one and
//    the output load before the result beat.
//  - Pass start sweeps all filled rows, a read and a live-counter clear per row.
//  - Export walks every entry against the merged entries so far up to a match,
//    a row read and sum step per entry plus a read and compare per merge
//    buffer entry, then emits each merged entry as a result beat.
//  - One command is worked at a time; s_axis_tready is high only when idle.
//  - The result waits in an output register; a stall of the receiver holds
//    it and the sequencer until it is taken.
//  - Reset empties the table (fill count zero) and restores the registers;
//    rows are cleared as they are inserted, so no clearing pass is needed.
`default_nettype none
`include "per_mark_traffic_accounting_table_unit_macros.svh"
module per_mark_traffic_accounting_table_unit
	import pmtat_pkg::*;
#(
	parameter int Entries = DefEntries
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_idx,
	input wire logic [31:0] cfg_data,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// action[2:0], mark[34:3], reply_bytes[66:35], orig_bytes[98:67],
	// dir_outbound[99], denied_bytes[130:100], zero fill to 136
	input wire logic [135:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// status[2:0], entry_valid[3], export_mark[35:4], total_in[99:36],
	// total_out[163:100], denied_in_total[227:164], denied_out_total[291:228]
	output logic [295:0] m_axis_tdata,
	output logic m_axis_tlast
);
	localparam int AW = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int CW = $clog2(Entries + 1);
	localparam logic [CW-1:0] FullCnt = CW'(Entries);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SRD = 4'd1;  // search: read issued
	localparam logic [3:0] S_SCMP = 4'd2; // search: compare
	localparam logic [3:0] S_UPD = 4'd3;  // write row back
	localparam logic [3:0] S_PASS = 4'd4; // clearing live counters
	localparam logic [3:0] S_PASSW = 4'd5;
	localparam logic [3:0] S_XRD = 4'd6;  // export: table row read
	localparam logic [3:0] S_XSUM = 4'd7; // export: form sums
	localparam logic [3:0] S_XMRD = 4'd8; // export: merge read
	localparam logic [3:0] S_XCMP = 4'd9; // export: merge compare
	localparam logic [3:0] S_ORD = 4'd10; // emit: read
	localparam logic [3:0] S_OEM = 4'd11; // emit: load output
	localparam logic [3:0] S_OUT = 4'd12; // raise output valid and return to idle

	logic [3:0] state_q;
	logic [31:0] base_q, offset_q;
	logic [CW-1:0] count_q;
	logic [2:0] act_q;
	logic [31:0] mark_q, ib_q, ob_q;
	logic dir_q;
	logic [30:0] db_q;
	logic [CW-1:0] idx_q, j_q, n_q;
	logic hit_q;
	logic out_v_q;
	res_t out_q;
	logic [31:0] xkey_q, xswap_q;
	logic xin_q;
	logic [63:0] ti_q, to_q, di_q, dq_q;

	// table memory
	logic st_we;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [31:0] st_wkey, st_rkey;
	cnt_row_t st_wrow, st_rrow;
	pmtat_store #(.Entries(Entries)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wkey(st_wkey), .wrow(st_wrow),
		.raddr(st_raddr), .rkey(st_rkey), .rrow(st_rrow)
	);

	// merge buffer
	logic mg_we;
	logic [AW-1:0] mg_waddr, mg_raddr;
	logic [31:0] mg_wkey, mg_rkey;
	logic [255:0] mg_wsum, mg_rsum;
	pmtat_merge #(.Entries(Entries)) u_merge (
		.clk(clk), .we(mg_we), .waddr(mg_waddr), .wkey(mg_wkey), .wsum(mg_wsum),
		.raddr(mg_raddr), .rkey(mg_rkey), .rsum(mg_rsum)
	);

	wire s_fire = s_axis_tvalid && s_axis_tready;
	wire m_fire = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {4'd0, out_q.denied_out_total, out_q.denied_in_total,
		out_q.total_out, out_q.total_in, out_q.export_mark, out_q.entry_valid,
		out_q.status};
	assign m_axis_tlast = out_q.last;

	// merge partner of the current export row
	wire [63:0] m_tin = mg_rsum[63:0];
	wire [63:0] m_tout = mg_rsum[127:64];
	wire [63:0] m_din = mg_rsum[191:128];
	wire [63:0] m_dout = mg_rsum[255:192];
	wire m_swap = xin_q && (xswap_q == mg_rkey);
	wire m_same = xkey_q == mg_rkey;
	// swap directions for a new inbound entry or a partner match, not a same-key match
	wire x_sw = (j_q == n_q) ? xin_q : m_swap;
	wire [63:0] a_ti = x_sw ? to_q : ti_q;
	wire [63:0] a_to = x_sw ? ti_q : to_q;
	wire [63:0] a_di = x_sw ? dq_q : di_q;
	wire [63:0] a_do = x_sw ? di_q : dq_q;

	// updated row for a sample
	cnt_row_t upd_row;
	always_comb begin
		upd_row = hit_q ? st_rrow : '0;
		unique case (act_q)
			ACT_LIVE: begin
				upd_row.live_in = upd_row.live_in + {32'd0, ib_q};
				upd_row.live_out = upd_row.live_out + {32'd0, ob_q};
			end
			ACT_GONE: begin
				upd_row.gone_in = upd_row.gone_in + {32'd0, ib_q};
				upd_row.gone_out = upd_row.gone_out + {32'd0, ob_q};
			end
			ACT_DENY: begin
				if (dir_q) upd_row.den_out = upd_row.den_out + {33'd0, db_q};
				else upd_row.den_in = upd_row.den_in + {33'd0, db_q};
			end
			default: begin
			end
		endcase
	end

	// memory control
	always_comb begin
		st_we = 1'b0;
		st_waddr = idx_q[AW-1:0];
		st_wkey = mark_q;
		st_wrow = upd_row;
		st_raddr = idx_q[AW-1:0];
		mg_we = 1'b0;
		mg_waddr = j_q[AW-1:0];
		mg_wkey = m_swap ? mg_rkey : xkey_q;
		mg_wsum = {m_dout + a_do, m_din + a_di, m_tout + a_to, m_tin + a_ti};
		mg_raddr = j_q[AW-1:0];
		if (state_q == S_UPD) st_we = 1'b1;
		if (state_q == S_PASSW) begin
			st_we = 1'b1;
			st_wkey = st_rkey;
			st_wrow = st_rrow;
			st_wrow.live_in = '0;
			st_wrow.live_out = '0;
		end
		if (state_q == S_XCMP && (j_q == n_q || m_swap || m_same)) begin
			mg_we = 1'b1;
			if (j_q == n_q) begin
				mg_wkey = xin_q ? xswap_q : xkey_q;
				mg_wsum = {a_do, a_di, a_to, a_ti};
			end
		end
	end

	function automatic res_t stat_res(input logic [2:0] st);
		res_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= DefBase;
			offset_q <= DefOffset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_BASE: base_q <= cfg_data;
				CFG_OFFSET: offset_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
			idx_q <= '0;
			j_q <= '0;
			n_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (m_fire) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						act_q <= s_axis_tdata[2:0];
						mark_q <= s_axis_tdata[34:3];
						ib_q <= s_axis_tdata[66:35];
						ob_q <= s_axis_tdata[98:67];
						dir_q <= s_axis_tdata[99];
						db_q <= s_axis_tdata[130:100];
						idx_q <= '0;
						j_q <= '0;
						n_q <= '0;
						hit_q <= 1'b0;
						if (s_axis_tdata[2:0] <= ACT_DENY && s_axis_tdata[34:3] != 32'd0)
							state_q <= S_SRD;
						else if (s_axis_tdata[2:0] == ACT_PASS)
							state_q <= (count_q == '0) ? S_OUT : S_PASS;
						else if (s_axis_tdata[2:0] == ACT_EXPORT)
							state_q <= (count_q == '0) ? S_OUT : S_XRD;
						else
							state_q <= S_OUT;
						out_q <= stat_res(s_axis_tdata[2:0] == ACT_PASS ? ST_UPDATED :
							(s_axis_tdata[2:0] == ACT_EXPORT ? ST_EXPORT : ST_IGNORED));
					end
				end
				S_SRD: begin
					if (idx_q == count_q) begin
						// not found
						if (act_q == ACT_GONE) begin
							out_q <= stat_res(ST_UNKNOWN);
							state_q <= S_OUT;
						end else if (count_q == FullCnt) begin
							out_q <= stat_res(ST_FULL);
							state_q <= S_OUT;
						end else begin
							out_q <= stat_res(ST_INSERTED);
							state_q <= S_UPD;
						end
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (st_rkey == mark_q) begin
						hit_q <= 1'b1;
						out_q <= stat_res(ST_UPDATED);
						state_q <= S_UPD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_UPD: begin
					if (!hit_q) count_q <= count_q + 1'b1;
					state_q <= S_OUT;
				end
				S_PASS: state_q <= S_PASSW;
				S_PASSW: begin
					if (idx_q + 1'b1 == count_q) begin
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_PASS;
					end
				end
				S_XRD: state_q <= S_XSUM;
				S_XSUM: begin
					xkey_q <= st_rkey;
					xin_q <= st_rkey >= base_q;
					xswap_q <= st_rkey - offset_q;
					ti_q <= st_rrow.live_in + st_rrow.gone_in;
					to_q <= st_rrow.live_out + st_rrow.gone_out;
					di_q <= st_rrow.den_in;
					dq_q <= st_rrow.den_out;
					j_q <= '0;
					state_q <= S_XMRD;
				end
				S_XMRD: state_q <= S_XCMP;
				S_XCMP: begin
					if (j_q == n_q || m_swap || m_same) begin
						if (j_q == n_q) n_q <= n_q + 1'b1;
						if (idx_q + 1'b1 == count_q) begin
							j_q <= '0;
							state_q <= S_ORD;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_XRD;
						end
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_XMRD;
					end
				end
				S_ORD: state_q <= S_OEM;
				S_OEM: begin
					if (!out_v_q || m_fire) begin
						out_q.status <= ST_EXPORT;
						out_q.entry_valid <= 1'b1;
						out_q.export_mark <= mg_rkey;
						out_q.total_in <= m_tin;
						out_q.total_out <= m_tout;
						out_q.denied_in_total <= m_din;
						out_q.denied_out_total <= m_dout;
						out_q.last <= (j_q + 1'b1 == n_q);
						out_v_q <= 1'b1;
						if (j_q + 1'b1 == n_q) begin
							state_q <= S_IDLE;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_ORD;
						end
					end
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	`PMT_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= FullCnt)
	`PMT_ASSERT_IMP(a_merge_le_count, clk, arst_n, 1'b1, n_q <= count_q)
	`PMT_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`PMT_ASSERT_IMP(a_no_take_busy, clk, arst_n, s_fire, !out_v_q)
endmodule
`default_nettype wire
